/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the vertex transform.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define VTP_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("vertex transform assertion failed");

// Clocked assertion that is also checked during reset.
`define VTP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("vertex transform assertion failed");

`endif

/* rtl/vtp_pkg.sv */
// Shared types and constants of the vertex transform with perspective divide.
// No dependencies.
package vtp_pkg;

    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_WORD_WIDTH = 32;
    localparam int LANES          = 3;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 64;

    // Matrix register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_C01 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_C01 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_C23 = 4'd7;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               w_zero;
        logic               saturated;
    } out_t;

    // Control that travels with an item through the divide stages.
    typedef struct packed {
        logic             valid;
        logic             wz;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] ovf;
    } div_ctl_t;

endpackage

/* rtl/vtp_mac.sv */
// Two pipeline stages: twelve products, then the four row sums.
// Depends on vtp_pkg.
module vtp_mac #(
    parameter int W  = vtp_pkg::DEF_WORD_WIDTH,
    parameter int F  = vtp_pkg::DEF_FRAC_BITS,
    parameter int AW = 50
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  vtp_pkg::in_t         in_data,
    input  logic [7:0][63:0]     mat,
    output logic                 out_valid,
    output logic                 out_point,
    output logic signed [AW-1:0] acc [4]
);

    logic signed [W-1:0]   ent [4][4];
    logic signed [W-1:0]   vin [3];
    logic signed [2*W-1:0] prod_reg [4][3];
    logic                  v1_reg, point1_reg;
    logic signed [AW-1:0]  acc_reg [4];
    logic signed [AW-1:0]  acc_next [4];
    logic                  v2_reg, point2_reg;

    for (genvar r = 0; r < 4; r++) begin : g_row
        for (genvar c = 0; c < 4; c++) begin : g_col
            assign ent[r][c] = mat[2*r + c/2][(c%2)*32 +: W];
        end
    end

    assign vin[0] = in_data.in_x[W-1:0];
    assign vin[1] = in_data.in_y[W-1:0];
    assign vin[2] = in_data.in_z[W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r][c] <= ent[r][c] * vin[c];
                end
            end
            point1_reg <= ~in_data.cmd;
            acc_reg    <= acc_next;
            point2_reg <= point1_reg;
        end
    end

    // Arithmetic shift floors each product; translation enters in point mode only.
    always_comb begin
        logic signed [2*W-1:0] sh;
        logic signed [AW-1:0]  s;
        for (int r = 0; r < 4; r++) begin
            s = point1_reg ? AW'(ent[r][3]) : '0;
            for (int c = 0; c < 3; c++) begin
                sh = prod_reg[r][c] >>> F;
                s  = s + signed'(sh[AW-1:0]);
            end
            acc_next[r] = s;
        end
    end

    assign out_valid = v2_reg;
    assign out_point = point2_reg;
    assign acc       = acc_reg;

endmodule

/* rtl/vtp_div_prep.sv */
// Two stages that set up the shared-divisor division of x, y and z by w.
// Depends on vtp_pkg.
module vtp_div_prep #(
    parameter int F  = vtp_pkg::DEF_FRAC_BITS,
    parameter int AW = 50,
    parameter int QB = 33
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic                 in_point,
    input  logic signed [AW-1:0] acc [4],
    output vtp_pkg::div_ctl_t    ctl,
    output logic [AW-1:0]        den,
    output logic [AW-1:0]        rem [3],
    output logic [QB-1:0]        low [3]
);

    localparam int NW = AW + F;

    logic [AW-1:0]     n_reg [3];
    logic [AW-1:0]     d_reg;
    logic [2:0]        neg_reg;
    logic              wz_reg, v3_reg;
    logic signed [AW-1:0] den_s;
    logic              wz_next;

    vtp_pkg::div_ctl_t ctl_reg;
    logic [AW-1:0]     d4_reg;
    logic [AW-1:0]     rem_reg [3];
    logic [QB-1:0]     low_reg [3];
    logic [NW-1:0]     num_w [3];
    logic [2:0]        ovf_next;

    // Direction mode and zero w both divide by 1.0, which leaves the value exact.
    assign wz_next = in_point && (acc[3] == '0);
    assign den_s   = (in_point && !wz_next) ? acc[3] : (AW'(1) << F);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg        <= 1'b0;
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            v3_reg        <= in_valid;
            ctl_reg.valid <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                n_reg[c]   <= acc[c][AW-1] ? AW'(-acc[c]) : AW'(acc[c]);
                neg_reg[c] <= acc[c][AW-1] ^ den_s[AW-1];
            end
            d_reg  <= den_s[AW-1] ? AW'(-den_s) : AW'(den_s);
            wz_reg <= wz_next;

            for (int c = 0; c < 3; c++) begin
                rem_reg[c] <= ovf_next[c] ? '0 : AW'(num_w[c][NW-1:QB]);
                low_reg[c] <= num_w[c][QB-1:0];
            end
            d4_reg      <= d_reg;
            ctl_reg.wz  <= wz_reg;
            ctl_reg.neg <= neg_reg;
            ctl_reg.ovf <= ovf_next;
        end
    end

    // A quotient wider than QB bits can only saturate.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            num_w[c]    = {n_reg[c], {F{1'b0}}};
            ovf_next[c] = NW'(num_w[c][NW-1:QB]) >= NW'(d_reg);
        end
    end

    assign ctl = ctl_reg;
    assign den = d4_reg;
    assign rem = rem_reg;
    assign low = low_reg;

endmodule

/* rtl/vtp_div_step.sv */
// One restoring-division stage: one quotient bit for each of three lanes.
// Depends on vtp_pkg.
module vtp_div_step #(
    parameter int AW = 50,
    parameter int QB = 33
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  vtp_pkg::div_ctl_t ctl_in,
    input  logic [AW-1:0]     den_in,
    input  logic [AW-1:0]     rem_in [3],
    input  logic [QB-1:0]     low_in [3],
    output vtp_pkg::div_ctl_t ctl_out,
    output logic [AW-1:0]     den_out,
    output logic [AW-1:0]     rem_out [3],
    output logic [QB-1:0]     low_out [3]
);

    vtp_pkg::div_ctl_t ctl_reg;
    logic [AW-1:0]     den_reg;
    logic [AW-1:0]     rem_reg [3];
    logic [QB-1:0]     low_reg [3];
    logic [AW-1:0]     rem_next [3];
    logic [QB-1:0]     low_next [3];

    // The dividend bits shift out of the top of low while quotient bits fill its bottom.
    always_comb begin
        logic [AW:0] trial;
        logic        ge;
        for (int c = 0; c < 3; c++) begin
            trial       = {rem_in[c], low_in[c][QB-1]};
            ge          = trial >= {1'b0, den_in};
            rem_next[c] = ge ? AW'(trial - {1'b0, den_in}) : trial[AW-1:0];
            low_next[c] = {low_in[c][QB-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg.valid <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg.wz  <= ctl_in.wz;
            ctl_reg.neg <= ctl_in.neg;
            ctl_reg.ovf <= ctl_in.ovf;
            den_reg     <= den_in;
            rem_reg     <= rem_next;
            low_reg     <= low_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign den_out = den_reg;
    assign rem_out = rem_reg;
    assign low_out = low_reg;

endmodule

/* rtl/vtp_post.sv */
// Output stage: sign, saturation, zero-w forcing and the result register.
// Depends on vtp_pkg.
module vtp_post #(
    parameter int W  = vtp_pkg::DEF_WORD_WIDTH,
    parameter int QB = 33
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  vtp_pkg::div_ctl_t ctl,
    input  logic [QB-1:0]     quo [3],
    output logic              m_valid,
    output vtp_pkg::out_t     m_data
);

    localparam logic signed [QB:0] VMAX = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [QB:0] VMIN = {3'b111, {(W-1){1'b0}}};

    logic                valid_reg;
    vtp_pkg::out_t       data_reg;
    vtp_pkg::out_t       data_next;
    logic signed [W-1:0] res [3];
    logic [2:0]          sat;

    always_comb begin
        logic signed [QB:0] q;
        logic signed [QB:0] v;
        for (int c = 0; c < 3; c++) begin
            q = signed'({1'b0, quo[c]});
            v = ctl.neg[c] ? -q : q;
            if (ctl.wz) begin
                res[c] = '0;
                sat[c] = 1'b0;
            end else if (ctl.ovf[c]) begin
                res[c] = ctl.neg[c] ? VMIN[W-1:0] : VMAX[W-1:0];
                sat[c] = 1'b1;
            end else if (v > VMAX) begin
                res[c] = VMAX[W-1:0];
                sat[c] = 1'b1;
            end else if (v < VMIN) begin
                res[c] = VMIN[W-1:0];
                sat[c] = 1'b1;
            end else begin
                res[c] = v[W-1:0];
                sat[c] = 1'b0;
            end
        end
        data_next.out_x     = 32'(res[0]);
        data_next.out_y     = 32'(res[1]);
        data_next.out_z     = 32'(res[2]);
        data_next.w_zero    = ctl.wz;
        data_next.saturated = |sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

/* rtl/vertex_transform_persp_divide.sv */
// The divider contributes one stage per quotient bit, WORD_WIDTH + 1 stages in all.
// Throughput: one vertex per clock; every stage advances together unless the output
// register holds a result that the consumer has not taken.
// Reset (aresetn, synchronous, active low) clears all valid bits and loads the identity matrix.
// Depends on vtp_pkg, vtp_mac, vtp_div_prep, vtp_div_step and vtp_post.
module vertex_transform_persp_divide #(
    parameter int FRAC_BITS  = vtp_pkg::DEF_FRAC_BITS,
    parameter int WORD_WIDTH = vtp_pkg::DEF_WORD_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  vtp_pkg::in_t                     s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output vtp_pkg::out_t                    m_data,
    input  logic                             cfg_we,
    input  logic [vtp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vtp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Accumulator width: room for three floored products plus the translation,
    // with sign and margin.
    localparam int AW = ((2*WORD_WIDTH - FRAC_BITS > WORD_WIDTH) ?
                         (2*WORD_WIDTH - FRAC_BITS) : WORD_WIDTH) + 2;
    // Quotient bits resolved by the divider; anything wider only saturates.
    localparam int QB = WORD_WIDTH + 1;
    localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

    function automatic logic [2:0] REG_IDX(input logic [vtp_pkg::CFG_IDX_W-1:0] idx);
        return idx[2:0];
    endfunction

    // The identity matrix: 1.0 on the diagonal, zero everywhere else.
    function automatic logic [7:0][63:0] mat_identity();
        logic [7:0][63:0] m;
        m = '0;
        m[REG_IDX(vtp_pkg::REG_ROW0_C01)] = ONE;
        m[REG_IDX(vtp_pkg::REG_ROW1_C01)] = ONE << 32;
        m[REG_IDX(vtp_pkg::REG_ROW2_C23)] = ONE;
        m[REG_IDX(vtp_pkg::REG_ROW3_C23)] = ONE << 32;
        return m;
    endfunction

    localparam logic [7:0][63:0] MAT_RESET = mat_identity();

    logic [7:0][63:0] mat_reg;
    logic             en;

    // The pipeline moves as one; it halts only while a finished result waits.
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Matrix registers. The user must send writes only while the pipeline is empty; the
    // block itself does not enforce it. Indexes beyond the last register are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg <= MAT_RESET;
        end else if (cfg_we && !cfg_index[vtp_pkg::CFG_IDX_W-1]) begin
            mat_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // Multiply and sum: two stages.
    logic                 mac_valid, mac_point;
    logic signed [AW-1:0] acc [4];

    vtp_mac #(.W(WORD_WIDTH), .F(FRAC_BITS), .AW(AW)) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid && s_ready),
        .in_data   (s_data),
        .mat       (mat_reg),
        .out_valid (mac_valid),
        .out_point (mac_point),
        .acc       (acc)
    );

    // Divider set-up and the chain of one-bit stages. Direction mode passes
    // through the same chain dividing by 1.0, so every item has the same latency.
    vtp_pkg::div_ctl_t ctl_s [QB+1];
    logic [AW-1:0]     den_s [QB+1];
    logic [AW-1:0]     rem_s [QB+1][3];
    logic [QB-1:0]     low_s [QB+1][3];

    vtp_div_prep #(.F(FRAC_BITS), .AW(AW), .QB(QB)) u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (mac_valid),
        .in_point (mac_point),
        .acc      (acc),
        .ctl      (ctl_s[0]),
        .den      (den_s[0]),
        .rem      (rem_s[0]),
        .low      (low_s[0])
    );

    for (genvar i = 0; i < QB; i++) begin : g_step
        vtp_div_step #(.AW(AW), .QB(QB)) u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (ctl_s[i]),
            .den_in  (den_s[i]),
            .rem_in  (rem_s[i]),
            .low_in  (low_s[i]),
            .ctl_out (ctl_s[i+1]),
            .den_out (den_s[i+1]),
            .rem_out (rem_s[i+1]),
            .low_out (low_s[i+1])
        );
    end

    // Sign, saturation and the output register.
    vtp_post #(.W(WORD_WIDTH), .QB(QB)) u_post (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl     (ctl_s[QB]),
        .quo     (low_s[QB]),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

/* rtl/vtp_checker.sv */
// Port-level checks for the vertex transform, bound to the top level.
// Depends on vtp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vtp_checker #(
    parameter int W = vtp_pkg::DEF_WORD_WIDTH
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input vtp_pkg::in_t                   s_data,
    input logic                           m_valid,
    input logic                           m_ready,
    input vtp_pkg::out_t                  m_data,
    input logic                           cfg_we,
    input logic [vtp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [vtp_pkg::CFG_DATA_W-1:0] cfg_data
);

    `VTP_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))
    `VTP_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid)
    `VTP_ASSERT(a_ready_only_stalls, aclk, aresetn, !s_ready |-> m_valid && !m_ready)
    `VTP_ASSERT(a_wzero_zeroes, aclk, aresetn, m_valid && m_data.w_zero |-> m_data.out_x == '0 && m_data.out_y == '0 && m_data.out_z == '0 && !m_data.saturated)
    `VTP_ASSERT(a_sign_extended, aclk, aresetn, m_valid |-> m_data.out_x[31:W-1] == {(33-W){m_data.out_x[W-1]}})

endmodule

bind vertex_transform_persp_divide vtp_checker #(.W(WORD_WIDTH)) u_vtp_checker (.*);
